// File: rtl/core/cmfs_pkg.sv
// ----------------------------------------------------------------------------
// cmfs_pkg
// Shared types and constants for the cube map face select unit.
// ----------------------------------------------------------------------------
package cmfs_pkg;

    localparam int COORD_BITS_DEF    = 16;
    localparam int UV_FRAC_BITS_DEF  = 16;
    localparam int MAX_FACE_SIZE_DEF = 4096;

    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;
    localparam int FACE_W    = 3;

    localparam logic [CFG_W-1:0]     CFG_SIZE_RESET  = CFG_W'(512);
    localparam logic [CFG_IDX_W-1:0] REG_FACE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FACE_HEIGHT = 1'b1;

    localparam logic [FACE_W-1:0] FACE_PX = 3'd0;
    localparam logic [FACE_W-1:0] FACE_PY = 3'd1;
    localparam logic [FACE_W-1:0] FACE_PZ = 3'd2;
    localparam logic [FACE_W-1:0] FACE_NX = 3'd3;
    localparam logic [FACE_W-1:0] FACE_NY = 3'd4;
    localparam logic [FACE_W-1:0] FACE_NZ = 3'd5;
    localparam logic [FACE_W-1:0] NEG_FACE_OFFSET = 3'd3;

    typedef struct packed {
        logic                valid;
        logic                invalid;
        logic [FACE_W-1:0]   face;
        logic                u_neg;
        logic                v_neg;
    } t_side;

endpackage

// File: rtl/core/cmfs_axis_sel.sv
// ----------------------------------------------------------------------------
// cmfs_axis_sel
// Head cell: magnitudes, major axis, face and minor axes with their signs.
// ----------------------------------------------------------------------------
module cmfs_axis_sel #(
    parameter int COORD_BITS = cmfs_pkg::COORD_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_ce,
    input  logic                    i_valid,
    input  logic [COORD_BITS-1:0]   i_dir_x,
    input  logic [COORD_BITS-1:0]   i_dir_y,
    input  logic [COORD_BITS-1:0]   i_dir_z,
    output cmfs_pkg::t_side         o_side,
    output logic [COORD_BITS-1:0]   o_major,
    output logic [COORD_BITS:0]     o_rem_u,
    output logic [COORD_BITS:0]     o_rem_v
);
    import cmfs_pkg::*;

    logic [COORD_BITS-1:0] mag_x, mag_y, mag_z, mag_m, mag_u, mag_v;
    logic                  neg_x, neg_y, neg_z, neg_m, neg_u, neg_v;
    logic [1:0]            m_sel;
    logic [FACE_W-1:0]     face;
    t_side                 n_side, r_side;
    logic [COORD_BITS-1:0] r_major;
    logic [COORD_BITS:0]   r_rem_u, r_rem_v;

    always_comb begin
        neg_x = i_dir_x[COORD_BITS-1];
        neg_y = i_dir_y[COORD_BITS-1];
        neg_z = i_dir_z[COORD_BITS-1];
        mag_x = neg_x ? (~i_dir_x + 1'b1) : i_dir_x;
        mag_y = neg_y ? (~i_dir_y + 1'b1) : i_dir_y;
        mag_z = neg_z ? (~i_dir_z + 1'b1) : i_dir_z;
        m_sel = 2'd0;
        mag_m = mag_x;
        neg_m = neg_x;
        if (mag_y > mag_m) begin
            m_sel = 2'd1;
            mag_m = mag_y;
            neg_m = neg_y;
        end
        if (mag_z > mag_m) begin
            m_sel = 2'd2;
            mag_m = mag_z;
            neg_m = neg_z;
        end
        face = FACE_W'(m_sel) + (neg_m ? NEG_FACE_OFFSET : '0);
        unique case (face)
            FACE_PX: begin
                mag_u = mag_z; neg_u = neg_z;  mag_v = mag_y; neg_v = neg_y;
            end
            FACE_PY: begin
                mag_u = mag_x; neg_u = neg_x;  mag_v = mag_z; neg_v = neg_z;
            end
            FACE_PZ: begin
                mag_u = mag_x; neg_u = ~neg_x; mag_v = mag_y; neg_v = neg_y;
            end
            FACE_NX: begin
                mag_u = mag_z; neg_u = ~neg_z; mag_v = mag_y; neg_v = neg_y;
            end
            FACE_NY: begin
                mag_u = mag_x; neg_u = neg_x;  mag_v = mag_z; neg_v = ~neg_z;
            end
            FACE_NZ: begin
                mag_u = mag_x; neg_u = neg_x;  mag_v = mag_y; neg_v = neg_y;
            end
            default: begin
                mag_u = '0; neg_u = 1'b0; mag_v = '0; neg_v = 1'b0;
            end
        endcase
        n_side.valid   = i_valid;
        n_side.invalid = (mag_m == '0);
        n_side.face    = face;
        n_side.u_neg   = neg_u;
        n_side.v_neg   = neg_v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= '0;
        end else if (i_ce) begin
            r_side <= n_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_major <= mag_m;
            r_rem_u <= {1'b0, mag_u};
            r_rem_v <= {1'b0, mag_v};
        end
    end

    assign o_side  = r_side;
    assign o_major = r_major;
    assign o_rem_u = r_rem_u;
    assign o_rem_v = r_rem_v;
endmodule

// File: rtl/core/cmfs_div_cell.sv
// ----------------------------------------------------------------------------
// cmfs_div_cell
// One restoring division step for u and v; yields one quotient bit each.
// ----------------------------------------------------------------------------
module cmfs_div_cell #(
    parameter int COORD_BITS   = cmfs_pkg::COORD_BITS_DEF,
    parameter int UV_FRAC_BITS = cmfs_pkg::UV_FRAC_BITS_DEF,
    parameter bit FIRST        = 1'b0
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_ce,
    input  cmfs_pkg::t_side           i_side,
    input  logic [COORD_BITS-1:0]     i_major,
    input  logic [COORD_BITS:0]       i_rem_u,
    input  logic [COORD_BITS:0]       i_rem_v,
    input  logic [UV_FRAC_BITS-1:0]   i_q_u,
    input  logic [UV_FRAC_BITS-1:0]   i_q_v,
    output cmfs_pkg::t_side           o_side,
    output logic [COORD_BITS-1:0]     o_major,
    output logic [COORD_BITS:0]       o_rem_u,
    output logic [COORD_BITS:0]       o_rem_v,
    output logic [UV_FRAC_BITS-1:0]   o_q_u,
    output logic [UV_FRAC_BITS-1:0]   o_q_v
);
    import cmfs_pkg::*;

    logic [COORD_BITS:0]       t_u, t_v, div;
    logic                      ge_u, ge_v;
    t_side                     r_side;
    logic [COORD_BITS-1:0]     r_major;
    logic [COORD_BITS:0]       r_rem_u, r_rem_v;
    logic [UV_FRAC_BITS-1:0]   r_q_u, r_q_v;

    always_comb begin
        div  = {1'b0, i_major};
        t_u  = FIRST ? i_rem_u : {i_rem_u[COORD_BITS-1:0], 1'b0};
        t_v  = FIRST ? i_rem_v : {i_rem_v[COORD_BITS-1:0], 1'b0};
        ge_u = (t_u >= div);
        ge_v = (t_v >= div);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= '0;
        end else if (i_ce) begin
            r_side <= i_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_major <= i_major;
            r_rem_u <= ge_u ? (t_u - div) : t_u;
            r_rem_v <= ge_v ? (t_v - div) : t_v;
            r_q_u   <= {i_q_u[UV_FRAC_BITS-2:0], ge_u};
            r_q_v   <= {i_q_v[UV_FRAC_BITS-2:0], ge_v};
        end
    end

    assign o_side  = r_side;
    assign o_major = r_major;
    assign o_rem_u = r_rem_u;
    assign o_rem_v = r_rem_v;
    assign o_q_u   = r_q_u;
    assign o_q_v   = r_q_v;
endmodule

// File: rtl/core/cmfs_texel.sv
// ----------------------------------------------------------------------------
// cmfs_texel
// Tail cell: centered uv fractions, texel scaling and the output register.
// ----------------------------------------------------------------------------
module cmfs_texel #(
    parameter int UV_FRAC_BITS  = cmfs_pkg::UV_FRAC_BITS_DEF,
    parameter int MAX_FACE_SIZE = cmfs_pkg::MAX_FACE_SIZE_DEF,
    localparam int TEXEL_W      = $clog2(MAX_FACE_SIZE)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_ce,
    input  cmfs_pkg::t_side                i_side,
    input  logic [UV_FRAC_BITS-1:0]        i_q_u,
    input  logic [UV_FRAC_BITS-1:0]        i_q_v,
    input  logic [cmfs_pkg::CFG_W-1:0]     i_face_width,
    input  logic [cmfs_pkg::CFG_W-1:0]     i_face_height,
    output logic                           o_valid,
    output logic                           o_invalid,
    output logic [cmfs_pkg::FACE_W-1:0]    o_face,
    output logic [UV_FRAC_BITS:0]          o_u_frac,
    output logic [UV_FRAC_BITS:0]          o_v_frac,
    output logic [TEXEL_W-1:0]             o_texel_x,
    output logic [TEXEL_W-1:0]             o_texel_y
);
    import cmfs_pkg::*;

    localparam int SIZE_W = $clog2(MAX_FACE_SIZE + 1);
    localparam int SW     = (CFG_W > SIZE_W) ? CFG_W : SIZE_W;
    localparam int PW     = UV_FRAC_BITS + 1 + SW;
    localparam logic [UV_FRAC_BITS:0] HALF = (UV_FRAC_BITS+1)'(1) << (UV_FRAC_BITS - 1);

    logic [SW-1:0]           w_ext, h_ext, w_m1, h_m1;
    logic [UV_FRAC_BITS:0]   u_frac, v_frac;
    logic [PW-1:0]           prod_x, prod_y;
    logic                    r_valid, r_invalid;
    logic [FACE_W-1:0]       r_face;
    logic [UV_FRAC_BITS:0]   r_u, r_v;
    logic [TEXEL_W-1:0]      r_tx, r_ty;

    function automatic logic [SW-1:0] size_m1(input logic [SW-1:0] s);
        logic [SW-1:0] c;
        if (s == '0) begin
            c = SW'(1);
        end else if (s > SW'(MAX_FACE_SIZE)) begin
            c = SW'(MAX_FACE_SIZE);
        end else begin
            c = s;
        end
        return c - SW'(1);
    endfunction

    always_comb begin
        w_ext  = SW'(i_face_width);
        h_ext  = SW'(i_face_height);
        w_m1   = size_m1(w_ext);
        h_m1   = size_m1(h_ext);
        u_frac = i_side.u_neg ? (HALF - (UV_FRAC_BITS+1)'(i_q_u))
                              : (HALF + (UV_FRAC_BITS+1)'(i_q_u));
        v_frac = i_side.v_neg ? (HALF - (UV_FRAC_BITS+1)'(i_q_v))
                              : (HALF + (UV_FRAC_BITS+1)'(i_q_v));
        prod_x = PW'(u_frac) * PW'(w_m1);
        prod_y = PW'(v_frac) * PW'(h_m1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ce) begin
            r_valid <= i_side.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_invalid <= i_side.invalid;
            if (i_side.invalid) begin
                r_face <= '0;
                r_u    <= '0;
                r_v    <= '0;
                r_tx   <= '0;
                r_ty   <= '0;
            end else begin
                r_face <= i_side.face;
                r_u    <= u_frac;
                r_v    <= v_frac;
                r_tx   <= prod_x[UV_FRAC_BITS +: TEXEL_W];
                r_ty   <= prod_y[UV_FRAC_BITS +: TEXEL_W];
            end
        end
    end

    assign o_valid   = r_valid;
    assign o_invalid = r_invalid;
    assign o_face    = r_face;
    assign o_u_frac  = r_u;
    assign o_v_frac  = r_v;
    assign o_texel_x = r_tx;
    assign o_texel_y = r_ty;
endmodule

// File: rtl/core/cube_map_face_select_uv_unit.sv
// ----------------------------------------------------------------------------
// cube_map_face_select_uv_unit
// Cube map face selection with face-local uv and texel coordinates.
//
// Requests enter on the slave stream: tdata carries dir_x, dir_y, dir_z.
// Results leave on the master stream: tdata carries face, u_frac, v_frac,
// texel_x, texel_y; tuser carries the invalid flag (all-zero direction).
// Face sizes are written through the plain write port (index 0 width,
// index 1 height); the user must write them only while the unit is idle,
// which the unit does not enforce; both reset to 512. The chain is one axis
// select cell, one division cell per quotient bit, one texel scaling cell.
// One request is accepted per cycle while not stalled. The chain advances
// as a whole; when the receiver stalls with a result waiting, the chain and
// o_s_tready hold. Reset empties the chain and restores the face sizes.
// ----------------------------------------------------------------------------
module cube_map_face_select_uv_unit #(
    parameter int COORD_BITS    = cmfs_pkg::COORD_BITS_DEF,
    parameter int UV_FRAC_BITS  = cmfs_pkg::UV_FRAC_BITS_DEF,
    parameter int MAX_FACE_SIZE = cmfs_pkg::MAX_FACE_SIZE_DEF,
    localparam int TEXEL_W      = $clog2(MAX_FACE_SIZE),
    localparam int IN_W         = ((3 * COORD_BITS + 7) / 8) * 8,
    localparam int OUT_RAW      = cmfs_pkg::FACE_W + 2 * (UV_FRAC_BITS + 1) + 2 * TEXEL_W,
    localparam int OUT_W        = ((OUT_RAW + 7) / 8) * 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [cmfs_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [cmfs_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [IN_W-1:0]                  i_s_tdata,   // dir_x, dir_y, dir_z
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [OUT_W-1:0]                 o_m_tdata,   // face, u_frac, v_frac, texel_x, texel_y
    output logic                             o_m_tuser    // invalid
);
    import cmfs_pkg::*;

    logic                    ce;
    logic [CFG_W-1:0]        r_face_width, r_face_height;
    t_side                   side  [0:UV_FRAC_BITS];
    logic [COORD_BITS-1:0]   major [0:UV_FRAC_BITS];
    logic [COORD_BITS:0]     rem_u [0:UV_FRAC_BITS];
    logic [COORD_BITS:0]     rem_v [0:UV_FRAC_BITS];
    logic [UV_FRAC_BITS-1:0] q_u   [0:UV_FRAC_BITS];
    logic [UV_FRAC_BITS-1:0] q_v   [0:UV_FRAC_BITS];
    logic                    out_valid, out_invalid;
    logic [FACE_W-1:0]       out_face;
    logic [UV_FRAC_BITS:0]   out_u, out_v;
    logic [TEXEL_W-1:0]      out_tx, out_ty;

    assign ce = ~out_valid | i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_face_width  <= CFG_SIZE_RESET;
            r_face_height <= CFG_SIZE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FACE_WIDTH:  r_face_width  <= i_cfg_data;
                REG_FACE_HEIGHT: r_face_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    cmfs_axis_sel #(.COORD_BITS(COORD_BITS)) u_sel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (i_s_tvalid),
        .i_dir_x (i_s_tdata[0 +: COORD_BITS]),
        .i_dir_y (i_s_tdata[COORD_BITS +: COORD_BITS]),
        .i_dir_z (i_s_tdata[2*COORD_BITS +: COORD_BITS]),
        .o_side  (side[0]),
        .o_major (major[0]),
        .o_rem_u (rem_u[0]),
        .o_rem_v (rem_v[0])
    );

    assign q_u[0] = '0;
    assign q_v[0] = '0;

    for (genvar k = 0; k < UV_FRAC_BITS; k++) begin : g_cell
        cmfs_div_cell #(
            .COORD_BITS   (COORD_BITS),
            .UV_FRAC_BITS (UV_FRAC_BITS),
            .FIRST        (k == 0)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ce    (ce),
            .i_side  (side[k]),
            .i_major (major[k]),
            .i_rem_u (rem_u[k]),
            .i_rem_v (rem_v[k]),
            .i_q_u   (q_u[k]),
            .i_q_v   (q_v[k]),
            .o_side  (side[k+1]),
            .o_major (major[k+1]),
            .o_rem_u (rem_u[k+1]),
            .o_rem_v (rem_v[k+1]),
            .o_q_u   (q_u[k+1]),
            .o_q_v   (q_v[k+1])
        );
    end

    cmfs_texel #(
        .UV_FRAC_BITS  (UV_FRAC_BITS),
        .MAX_FACE_SIZE (MAX_FACE_SIZE)
    ) u_texel (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ce          (ce),
        .i_side        (side[UV_FRAC_BITS]),
        .i_q_u         (q_u[UV_FRAC_BITS]),
        .i_q_v         (q_v[UV_FRAC_BITS]),
        .i_face_width  (r_face_width),
        .i_face_height (r_face_height),
        .o_valid       (out_valid),
        .o_invalid     (out_invalid),
        .o_face        (out_face),
        .o_u_frac      (out_u),
        .o_v_frac      (out_v),
        .o_texel_x     (out_tx),
        .o_texel_y     (out_ty)
    );

    assign o_s_tready = ce;
    assign o_m_tvalid = out_valid;
    assign o_m_tuser  = out_invalid;
    assign o_m_tdata  = OUT_W'({out_ty, out_tx, out_v, out_u, out_face});
endmodule

// File: rtl/core/cmfs_checker.sv
// ----------------------------------------------------------------------------
// cmfs_checker
// Port-level checks for the cube map face select unit, bound to the top.
// ----------------------------------------------------------------------------
module cmfs_checker #(
    parameter int UV_FRAC_BITS  = cmfs_pkg::UV_FRAC_BITS_DEF,
    parameter int MAX_FACE_SIZE = cmfs_pkg::MAX_FACE_SIZE_DEF,
    localparam int TEXEL_W      = $clog2(MAX_FACE_SIZE),
    localparam int OUT_RAW      = cmfs_pkg::FACE_W + 2 * (UV_FRAC_BITS + 1) + 2 * TEXEL_W,
    localparam int OUT_W        = ((OUT_RAW + 7) / 8) * 8
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_s_tready,
    input logic                             o_m_tvalid,
    input logic                             i_m_tready,
    input logic [OUT_W-1:0]                 o_m_tdata,
    input logic                             o_m_tuser
);
    import cmfs_pkg::*;

    logic [FACE_W-1:0] face_f;
    assign face_f = o_m_tdata[FACE_W-1:0];

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result changed while stalled");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready == (!o_m_tvalid || i_m_tready))
        else $error("request ready does not follow output stall");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata == '0)
        else $error("invalid result carries nonzero data");

    a_face: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> face_f <= FACE_NZ)
        else $error("face code out of range");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");
endmodule

bind cube_map_face_select_uv_unit cmfs_checker #(
    .UV_FRAC_BITS  (UV_FRAC_BITS),
    .MAX_FACE_SIZE (MAX_FACE_SIZE)
) u_cmfs_checker (.*);
